// ===== src/mrope_pkg.sv =====
// Shared types and constants for the multimodal rotary position id generator.
// No dependencies.
package mrope_pkg;

	localparam int MaxSpans = 16;
	localparam int SpanIdxW = $clog2(MaxSpans);

	localparam logic [1:0] REQ_TOKEN = 2'd0;
	localparam logic [1:0] REQ_PAD   = 2'd1;
	localparam logic [1:0] REQ_LOAD  = 2'd2;

	// division steps, in issue order
	localparam logic [2:0] DIV_GH = 3'd0;
	localparam logic [2:0] DIV_GW = 3'd1;
	localparam logic [2:0] DIV_K  = 3'd2;
	localparam logic [2:0] DIV_Q1 = 3'd3;
	localparam logic [2:0] DIV_T  = 3'd4;

	localparam logic [0:0] REG_MERGE_DIV = 1'b0;
	localparam logic [7:0] MergeSizeReset = 8'd2;

	// controller -> datapath
	typedef struct packed {
		logic                load;      // capture input item
		logic                tbl_wr;    // write span table entry
		logic                scan_clr;  // reset span pointer
		logic                scan_step; // evaluate entry, advance pointer on a miss
		logic                div_start;
		logic [2:0]          div_sel;
		logic                div_take;  // store divider result
		logic                finish_emb;
		logic                finish_seq;
	} ctrl_t;

	// datapath -> controller
	typedef struct packed {
		logic [1:0] req;
		logic       hit;       // current entry matches
		logic       scan_last; // current entry is the last
		logic       div_done;
	} stat_t;

endpackage

// ===== src/mrope_position_id_generator.sv =====
// Top level of the multimodal rotary position id generator.
// Depends on mrope_pkg, mrope_ctrl, mrope_dp, mrope_div.
//
//  channel | handshake             | payload
//  in      | in_valid / in_ready   | req_type first token_id span_* grid_*
//  out     | out_valid / out_ready | pos_time pos_height pos_width is_embedding next_base
//  cfg     | psel penable pwrite   | paddr pwdata prdata (merge divisor)
//
// A load or an unknown request goes back from the decode state to idle, freeing the input.
// Padding goes from decode straight to its result; a token scans one span entry
// a cycle (up to 16), and a miss shows its result right after the scan.
// A hit runs five divisions in turn on one shared divider before its result is shown.
// The result holds until taken, and the input stays closed meanwhile.
// Reset clears the span table and bases, and sets the merge divisor to 2.
module mrope_position_id_generator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  req_type,
	input  logic        first,
	input  logic [31:0] token_id,
	input  logic [3:0]  span_index,
	input  logic [31:0] span_first_id,
	input  logic [31:0] span_end_id,
	input  logic [15:0] grid_time,
	input  logic [15:0] grid_height,
	input  logic [15:0] grid_width,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] pos_time,
	output logic [31:0] pos_height,
	output logic [31:0] pos_width,
	output logic        is_embedding,
	output logic [31:0] next_base,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [0:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	mrope_pkg::ctrl_t ctrl;
	mrope_pkg::stat_t stat;
	logic [7:0] merge_q;

	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			merge_q <= mrope_pkg::MergeSizeReset;
		else if (psel && penable && pwrite && paddr == mrope_pkg::REG_MERGE_DIV)
			merge_q <= pwdata[7:0];
	end
	assign prdata = (paddr == mrope_pkg::REG_MERGE_DIV) ? {24'd0, merge_q} : 32'd0;

	mrope_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.out_valid(out_valid), .out_ready(out_ready), .ctrl(ctrl), .stat(stat)
	);

	mrope_dp u_dp (
		.clk(clk), .arst_n(arst_n), .ctrl(ctrl), .stat(stat), .merge_div(merge_q),
		.req_type(req_type), .first(first), .token_id(token_id),
		.span_index(span_index), .span_first_id(span_first_id),
		.span_end_id(span_end_id), .grid_time(grid_time),
		.grid_height(grid_height), .grid_width(grid_width),
		.pos_time(pos_time), .pos_height(pos_height), .pos_width(pos_width),
		.is_embedding(is_embedding), .next_base(next_base)
	);

	a_no_in_while_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready) else $error("input taken while result pending");
	a_out_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(pos_time) && $stable(next_base))
		else $error("result changed while stalled");
	a_one_load: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready) else $error("second item taken at once");
endmodule

// ===== src/mrope_div.sv =====
// Restoring 32-bit unsigned divider, one quotient bit per cycle.
// Does not use mrope_pkg; self-contained.
module mrope_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] dividend,
	input  logic [31:0] divisor,
	output logic        done,
	output logic [31:0] quot,
	output logic [31:0] rem
);
	logic [31:0] quot_q, rem_q, dvs_q;
	logic [5:0]  cnt_q;
	logic        busy_q, done_q;
	logic [32:0] trial;

	assign trial = {rem_q, quot_q[31]} - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quot_q <= dividend;
			rem_q  <= '0;
			dvs_q  <= divisor;
		end else if (busy_q) begin
			if (!trial[32]) begin
				rem_q  <= trial[31:0];
				quot_q <= {quot_q[30:0], 1'b1};
			end else begin
				rem_q  <= {rem_q[30:0], quot_q[31]};
				quot_q <= {quot_q[30:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign quot = quot_q;
	assign rem  = rem_q;
endmodule

// ===== src/mrope_dp.sv =====
// Datapath: span table, scan pointer, shared divider, base registers.
// Depends on mrope_pkg and mrope_div.
module mrope_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  mrope_pkg::ctrl_t    ctrl,
	output mrope_pkg::stat_t    stat,
	input  logic [7:0]          merge_div,
	input  logic [1:0]          req_type,
	input  logic                first,
	input  logic [31:0]         token_id,
	input  logic [3:0]          span_index,
	input  logic [31:0]         span_first_id,
	input  logic [31:0]         span_end_id,
	input  logic [15:0]         grid_time,
	input  logic [15:0]         grid_height,
	input  logic [15:0]         grid_width,
	output logic [31:0]         pos_time,
	output logic [31:0]         pos_height,
	output logic [31:0]         pos_width,
	output logic                is_embedding,
	output logic [31:0]         next_base
);
	localparam int IW = mrope_pkg::SpanIdxW;

	logic [31:0] st_q [mrope_pkg::MaxSpans];
	logic [31:0] en_q [mrope_pkg::MaxSpans];
	logic [15:0] gt_q [mrope_pkg::MaxSpans];
	logic [15:0] gh_q [mrope_pkg::MaxSpans];
	logic [15:0] gw_q [mrope_pkg::MaxSpans];

	logic [1:0]  req_q;
	logic        first_q;
	logic [31:0] id_q, ld_st_q, ld_en_q;
	logic [3:0]  ld_idx_q;
	logic [15:0] ld_gt_q, ld_gh_q, ld_gw_q;
	logic [IW-1:0] ptr_q;
	logic [31:0] k_q, gt_sel_q, gh_sel_q, gw_sel_q, raw_h_q, raw_w_q;
	logic [31:0] q1_q, rw_q, rh_q;
	logic [31:0] base_q, nbase_q;
	logic [31:0] pt_q, ph_q, pw_q;
	logic        emb_q;

	logic [7:0]  ms;
	logic        hit;
	logic [31:0] dvd, dvs, quo, rem;
	logic        dn;
	logic [31:0] b0, nb0, pt, ph, pw, m1, m2;

	assign ms  = (merge_div == 8'd0) ? 8'd1 : merge_div;
	assign hit = (id_q >= st_q[ptr_q]) && (id_q < en_q[ptr_q]) &&
		(gt_q[ptr_q] != 16'd0) && (gh_q[ptr_q] >= {8'd0, ms}) &&
		(gw_q[ptr_q] >= {8'd0, ms});

	// sequence of divisions: gh/ms, gw/ms, k/gw, q1/gh, (q1/gh)%gt
	always_comb begin
		dvd = k_q;
		dvs = gw_sel_q;
		case (ctrl.div_sel)
			mrope_pkg::DIV_GH: begin dvd = raw_h_q; dvs = {24'd0, ms}; end
			mrope_pkg::DIV_GW: begin dvd = raw_w_q; dvs = {24'd0, ms}; end
			mrope_pkg::DIV_K:  begin dvd = k_q;     dvs = gw_sel_q;    end
			mrope_pkg::DIV_Q1: begin dvd = q1_q;    dvs = gh_sel_q;    end
			mrope_pkg::DIV_T:  begin dvd = q1_q;    dvs = gt_sel_q;    end
			default: ;
		endcase
	end

	mrope_div u_div (
		.clk(clk), .arst_n(arst_n), .start(ctrl.div_start),
		.dividend(dvd), .divisor(dvs), .done(dn), .quot(quo), .rem(rem)
	);

	// step counter for the chained divisions
	logic [2:0] dstep_q;

	assign b0  = first_q ? 32'd0 : base_q;
	assign nb0 = first_q ? 32'd0 : nbase_q;
	assign pt  = b0 + rem;
	assign ph  = b0 + rh_q;
	assign pw  = b0 + rw_q;
	always_comb begin
		m1 = (pt + 32'd1 > nb0) ? pt + 32'd1 : nb0;
		m2 = (ph + 32'd1 > m1) ? ph + 32'd1 : m1;
		if (pw + 32'd1 > m2)
			m2 = pw + 32'd1;
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			req_q    <= req_type;
			first_q  <= first;
			id_q     <= token_id;
			ld_idx_q <= span_index;
			ld_st_q  <= span_first_id;
			ld_en_q  <= span_end_id;
			ld_gt_q  <= grid_time;
			ld_gh_q  <= grid_height;
			ld_gw_q  <= grid_width;
		end
		if (ctrl.scan_step && hit) begin
			k_q      <= id_q - st_q[ptr_q];
			gt_sel_q <= {16'd0, gt_q[ptr_q]};
			raw_h_q  <= {16'd0, gh_q[ptr_q]};
			raw_w_q  <= {16'd0, gw_q[ptr_q]};
		end
		if (ctrl.div_take) begin
			case (dstep_q)
				mrope_pkg::DIV_GH: gh_sel_q <= quo;
				mrope_pkg::DIV_GW: gw_sel_q <= quo;
				mrope_pkg::DIV_K:  begin q1_q <= quo; rw_q <= rem; end
				mrope_pkg::DIV_Q1: begin q1_q <= quo; rh_q <= rem; end
				default: ;
			endcase
		end
		if (ctrl.finish_emb) begin
			pt_q  <= pt;
			ph_q  <= ph;
			pw_q  <= pw;
			emb_q <= 1'b1;
		end else if (ctrl.finish_seq) begin
			pt_q  <= nb0;
			ph_q  <= nb0;
			pw_q  <= nb0;
			emb_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q  <= '0;
			nbase_q <= '0;
			ptr_q   <= '0;
			dstep_q <= '0;
			for (int i = 0; i < mrope_pkg::MaxSpans; i++) begin
				st_q[i] <= '0;
				en_q[i] <= '0;
				gt_q[i] <= '0;
				gh_q[i] <= '0;
				gw_q[i] <= '0;
			end
		end else begin
			if (ctrl.tbl_wr && ({28'd0, ld_idx_q} < mrope_pkg::MaxSpans)) begin
				st_q[ld_idx_q[IW-1:0]] <= ld_st_q;
				en_q[ld_idx_q[IW-1:0]] <= ld_en_q;
				gt_q[ld_idx_q[IW-1:0]] <= ld_gt_q;
				gh_q[ld_idx_q[IW-1:0]] <= ld_gh_q;
				gw_q[ld_idx_q[IW-1:0]] <= ld_gw_q;
			end
			if (ctrl.scan_clr) begin
				ptr_q   <= '0;
				dstep_q <= '0;
			end else begin
				if (ctrl.scan_step && !hit)
					ptr_q <= ptr_q + 1'b1;
				if (ctrl.div_take)
					dstep_q <= dstep_q + 3'd1;
			end
			if (ctrl.finish_emb) begin
				base_q  <= b0;
				nbase_q <= m2;
			end else if (ctrl.finish_seq) begin
				base_q  <= nb0 + 32'd1;
				nbase_q <= nb0 + 32'd1;
			end
		end
	end

	assign stat.req       = req_q;
	assign stat.hit       = hit;
	assign stat.scan_last = (ptr_q == IW'(mrope_pkg::MaxSpans - 1));
	assign stat.div_done  = dn;

	assign pos_time     = pt_q;
	assign pos_height   = ph_q;
	assign pos_width    = pw_q;
	assign is_embedding = emb_q;
	assign next_base    = nbase_q;
endmodule

// ===== src/mrope_ctrl.sv =====
// Controller state machine sequencing load, span scan and divisions.
// Depends on mrope_pkg.
module mrope_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	output mrope_pkg::ctrl_t ctrl,
	input  mrope_pkg::stat_t stat
);
	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,
		S_DEC  = 7'b0000010,
		S_SCAN = 7'b0000100,
		S_DST  = 7'b0001000,
		S_DWT  = 7'b0010000,
		S_FIN  = 7'b0100000,
		S_OUT  = 7'b1000000
	} state_t;

	state_t state_q, state_d;
	logic [2:0] nd_q;
	logic       seq_d;

	always_comb begin
		state_d = state_q;
		ctrl    = '0;
		seq_d   = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					ctrl.load = 1'b1;
					state_d   = S_DEC;
				end
			end
			S_DEC: begin
				ctrl.scan_clr = 1'b1;
				case (stat.req)
					mrope_pkg::REQ_LOAD: begin
						ctrl.tbl_wr = 1'b1;
						state_d     = S_IDLE;
					end
					mrope_pkg::REQ_TOKEN: state_d = S_SCAN;
					mrope_pkg::REQ_PAD: begin
						ctrl.finish_seq = 1'b1;
						state_d         = S_OUT;
					end
					default: state_d = S_IDLE;
				endcase
			end
			S_SCAN: begin
				ctrl.scan_step = 1'b1;
				if (stat.hit)
					state_d = S_DST;
				else if (stat.scan_last) begin
					ctrl.finish_seq = 1'b1;
					state_d         = S_OUT;
				end
			end
			S_DST: begin
				ctrl.div_start = 1'b1;
				ctrl.div_sel   = nd_q;
				state_d        = S_DWT;
			end
			S_DWT: begin
				ctrl.div_sel = nd_q;
				if (stat.div_done) begin
					ctrl.div_take = 1'b1;
					state_d       = (nd_q == mrope_pkg::DIV_T) ? S_FIN : S_DST;
				end
			end
			S_FIN: begin
				ctrl.div_sel = nd_q;
				state_d      = S_OUT;
			end
			S_OUT: begin
				if (out_ready)
					state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
		if (state_q == S_DWT && stat.div_done && nd_q == mrope_pkg::DIV_T)
			ctrl.finish_emb = 1'b1;
		seq_d = ctrl.finish_emb;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			nd_q    <= '0;
		end else begin
			state_q <= state_d;
			if (ctrl.scan_clr)
				nd_q <= '0;
			else if (ctrl.div_take && !seq_d)
				nd_q <= nd_q + 3'd1;
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = (state_q == S_OUT);
endmodule

// ===== bench/tb_mrope_position_id_generator.sv =====
// Testbench for mrope_position_id_generator: loads span tables, streams token,
// padding, load and unknown items, and checks every position result against a predictor.
// Depends on mrope_pkg and the RTL under src.
`timescale 1ns / 100ps

module tb_mrope_position_id_generator;

	localparam logic [1:0] REQ_NONE = 2'd3;

	typedef struct {
		logic [1:0]  req;
		logic        first;
		logic [31:0] id;
		logic [3:0]  idx;
		logic [31:0] sfirst;
		logic [31:0] send;
		logic [15:0] gt;
		logic [15:0] gh;
		logic [15:0] gw;
	} item_t;

	typedef struct {
		logic [31:0] t;
		logic [31:0] h;
		logic [31:0] w;
		logic        emb;
		logic [31:0] nb;
	} pos_t;

	class mrope_scoreboard;
		logic [31:0] span_lo [mrope_pkg::MaxSpans];
		logic [31:0] span_hi [mrope_pkg::MaxSpans];
		logic [15:0] tbl_gt [mrope_pkg::MaxSpans];
		logic [15:0] tbl_gh [mrope_pkg::MaxSpans];
		logic [15:0] tbl_gw [mrope_pkg::MaxSpans];
		logic [31:0] base, nbase;
		logic [7:0]  merge;
		pos_t        pending_positions[$];
		int          errors;

		function new();
			for (int j = 0; j < mrope_pkg::MaxSpans; j++) begin
				span_lo[j] = '0; span_hi[j] = '0;
				tbl_gt[j] = '0; tbl_gh[j] = '0; tbl_gw[j] = '0;
			end
			base = '0;
			nbase = '0;
			merge = mrope_pkg::MergeSizeReset;
			errors = 0;
		endfunction

		function void set_merge(logic [31:0] v);
			merge = v[7:0];
		endfunction

		// a load fills the table, a token or pad advances base and queues ids
		function void record_request(item_t it);
			logic [31:0] ms, gt, gh, gw, k, m;
			pos_t p;
			if (it.req == mrope_pkg::REQ_LOAD) begin
				span_lo[it.idx] = it.sfirst;
				span_hi[it.idx] = it.send;
				tbl_gt[it.idx] = it.gt;
				tbl_gh[it.idx] = it.gh;
				tbl_gw[it.idx] = it.gw;
				return;
			end
			if (it.req == REQ_NONE)
				return;
			ms = (merge == 8'd0) ? 32'd1 : {24'd0, merge};
			if (it.first) begin
				base = '0;
				nbase = '0;
			end
			p.emb = 1'b0;
			if (it.req == mrope_pkg::REQ_TOKEN) begin
				for (int j = 0; j < mrope_pkg::MaxSpans; j++) begin
					gt = {16'd0, tbl_gt[j]};
					gh = {16'd0, tbl_gh[j]} / ms;
					gw = {16'd0, tbl_gw[j]} / ms;
					if (!(it.id >= span_lo[j] && it.id < span_hi[j]))
						continue;
					if (gt == 32'd0 || gh == 32'd0 || gw == 32'd0)
						continue;
					k = it.id - span_lo[j];
					p.t = base + (k / gw / gh) % gt;
					p.h = base + (k / gw) % gh;
					p.w = base + k % gw;
					m = p.t + 32'd1; if (m > nbase) nbase = m;
					m = p.h + 32'd1; if (m > nbase) nbase = m;
					m = p.w + 32'd1; if (m > nbase) nbase = m;
					p.emb = 1'b1;
					break;
				end
			end
			if (!p.emb) begin
				base = nbase;
				p.t = base; p.h = base; p.w = base;
				base = base + 32'd1;
				nbase = base;
			end
			p.nb = nbase;
			pending_positions.push_back(p);
		endfunction

		function void check_position(pos_t got);
			pos_t exp_p;
			if (pending_positions.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result t=%h h=%h w=%h emb=%b nb=%h",
						got.t, got.h, got.w, got.emb, got.nb);
				return;
			end
			exp_p = pending_positions.pop_front();
			if (got.t !== exp_p.t || got.h !== exp_p.h || got.w !== exp_p.w ||
				got.emb !== exp_p.emb || got.nb !== exp_p.nb) begin
				errors++;
				if (errors <= 10)
					$display({"mismatch exp t=%h h=%h w=%h emb=%b nb=%h,",
						" got t=%h h=%h w=%h emb=%b nb=%h"},
						exp_p.t, exp_p.h, exp_p.w, exp_p.emb, exp_p.nb,
						got.t, got.h, got.w, got.emb, got.nb);
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [1:0]  req_type = '0;
	logic        first = 1'b0;
	logic [31:0] token_id = '0;
	logic [3:0]  span_index = '0;
	logic [31:0] span_first_id = '0;
	logic [31:0] span_end_id = '0;
	logic [15:0] grid_time = '0;
	logic [15:0] grid_height = '0;
	logic [15:0] grid_width = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [31:0] pos_time, pos_height, pos_width, next_base;
	logic        is_embedding;
	logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [0:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	mrope_scoreboard sb = new();
	int hold_cycles = 0;
	int burst_left = 0;
	int sent = 0;

	mrope_position_id_generator uut (.*);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		item_t it;
		pos_t  p;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				it.req = req_type; it.first = first; it.id = token_id;
				it.idx = span_index; it.sfirst = span_first_id; it.send = span_end_id;
				it.gt = grid_time; it.gh = grid_height; it.gw = grid_width;
				sb.record_request(it);
			end
			if (out_valid && out_ready) begin
				p.t = pos_time; p.h = pos_height; p.w = pos_width;
				p.emb = is_embedding; p.nb = next_base;
				sb.check_position(p);
			end
		end
	end

	// receiver: stall pattern changes mode every so often; a long hold-off wins
	initial begin
		int mode, left;
		mode = 0;
		left = 0;
		forever begin
			@(negedge clk);
			if (left == 0) begin
				mode = $urandom_range(0, 2);
				left = $urandom_range(64, 256);
			end
			left--;
			if (hold_cycles > 0) begin
				hold_cycles--;
				out_ready <= 1'b0;
			end else if (mode == 0)
				out_ready <= 1'b1;
			else if (mode == 1)
				out_ready <= 1'($urandom_range(0, 1));
			else
				out_ready <= ($urandom_range(0, 4) == 0);
		end
	end

	initial begin
		#20_000_000;
		$display("tb: failure");
		$finish;
	end

	task automatic send_item(item_t it);
		@(negedge clk);
		in_valid <= 1'b1;
		req_type <= it.req; first <= it.first; token_id <= it.id;
		span_index <= it.idx; span_first_id <= it.sfirst; span_end_id <= it.send;
		grid_time <= it.gt; grid_height <= it.gh; grid_width <= it.gw;
		do @(posedge clk); while (!in_ready);
		if (it.req != REQ_NONE)
			sent++;
		if (burst_left > 0)
			burst_left--;
		else begin
			burst_left = $urandom_range(0, 20);
			@(negedge clk);
			in_valid <= 1'b0;
			repeat ($urandom_range(0, 40)) @(negedge clk);
		end
	endtask

	// stop offering, then wait for every expected result
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.pending_positions.size() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	task automatic write_merge(logic [7:0] ms);
		logic [31:0] v;
		v = {24'($urandom_range(0, 32'hFFFFFF)), ms};
		@(negedge clk);
		in_valid <= 1'b0;
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
		paddr <= mrope_pkg::REG_MERGE_DIV; pwdata <= v;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		sb.set_merge(v);
		@(negedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
	endtask

	function automatic item_t mk(logic [1:0] req, logic fst, logic [31:0] id);
		item_t it;
		it.req = req; it.first = fst; it.id = id;
		it.idx = 4'($urandom); it.sfirst = $urandom; it.send = $urandom;
		it.gt = 16'($urandom); it.gh = 16'($urandom); it.gw = 16'($urandom);
		return it;
	endfunction

	function automatic item_t mk_load(int idx, logic [31:0] lo, logic [31:0] hi,
		logic [15:0] gt, logic [15:0] gh, logic [15:0] gw);
		item_t it;
		it = mk(mrope_pkg::REQ_LOAD, 1'($urandom_range(0, 1)), $urandom);
		it.idx = 4'(idx); it.sfirst = lo; it.send = hi;
		it.gt = gt; it.gh = gh; it.gw = gw;
		return it;
	endfunction

	// token id aimed at a span of the current table, sometimes just outside it
	function automatic logic [31:0] pick_id();
		int j;
		logic [31:0] r;
		j = $urandom_range(0, mrope_pkg::MaxSpans - 1);
		r = sb.span_hi[j] - sb.span_lo[j];
		case ($urandom_range(0, 9))
			0: return sb.span_hi[j];
			1: return sb.span_lo[j] - 32'd1;
			default: return (r == 32'd0) ? sb.span_lo[j] : sb.span_lo[j] + ($urandom % r);
		endcase
	endfunction

	task automatic random_phase(int count);
		item_t it;
		int stop, lo;
		stop = sent + count;
		while (sent < stop) begin
			if ($urandom_range(0, 9) < 8) begin
				// well-formed: reload a few spans, then a token sequence
				repeat ($urandom_range(0, 3)) begin
					lo = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 5000);
					if ($urandom_range(0, 7) == 0)
						send_item(mk_load($urandom_range(0, 15), lo, $urandom,
							16'($urandom), 16'($urandom), 16'($urandom)));
					else
						send_item(mk_load($urandom_range(0, 15), lo,
							lo + $urandom_range(0, 300), 16'($urandom_range(0, 4)),
							16'($urandom_range(0, 12)), 16'($urandom_range(0, 12))));
				end
				send_item(mk(mrope_pkg::REQ_TOKEN, 1'b1, pick_id()));
				repeat ($urandom_range(1, 12)) begin
					if ($urandom_range(0, 5) == 0)
						send_item(mk(mrope_pkg::REQ_PAD, 1'b0, $urandom));
					else
						send_item(mk(mrope_pkg::REQ_TOKEN, 1'b0, pick_id()));
				end
			end else begin
				case ($urandom_range(0, 3))
					0: send_item(mk(REQ_NONE, 1'($urandom_range(0, 1)), $urandom));
					1: send_item(mk(mrope_pkg::REQ_LOAD, 1'($urandom_range(0, 1)),
						$urandom));
					default: send_item(mk(2'($urandom_range(0, 1)),
						1'($urandom_range(0, 1)), $urandom));
				endcase
			end
		end
	endtask

	initial begin
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		// directed: reset table, overlap, empty spans, zero dims, extremes
		send_item(mk(mrope_pkg::REQ_TOKEN, 1'b1, 32'd0));
		send_item(mk(mrope_pkg::REQ_TOKEN, 1'b0, 32'hFFFFFFFF));
		send_item(mk_load(0, 100, 124, 16'd2, 16'd4, 16'd6));
		send_item(mk_load(1, 110, 200, 16'd3, 16'd5, 16'd5));
		send_item(mk_load(2, 300, 300, 16'd1, 16'd2, 16'd2));
		send_item(mk_load(3, 500, 400, 16'd1, 16'd2, 16'd2));
		send_item(mk_load(4, 600, 700, 16'd2, 16'd1, 16'd4));
		send_item(mk_load(15, 32'hFFFFF000, 32'hFFFFFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
		send_item(mk(mrope_pkg::REQ_TOKEN, 1'b1, 32'd100));
		send_item(mk(mrope_pkg::REQ_TOKEN, 1'b0, 32'd123));
		send_item(mk(mrope_pkg::REQ_TOKEN, 1'b0, 32'd124));
		send_item(mk(mrope_pkg::REQ_TOKEN, 1'b0, 32'd199));
		send_item(mk(mrope_pkg::REQ_TOKEN, 1'b0, 32'd300));
		send_item(mk(mrope_pkg::REQ_TOKEN, 1'b0, 32'd450));
		send_item(mk(mrope_pkg::REQ_TOKEN, 1'b0, 32'd650));
		send_item(mk(mrope_pkg::REQ_PAD, 1'b0, 32'd0));
		send_item(mk(REQ_NONE, 1'b1, 32'd100));
		send_item(mk(mrope_pkg::REQ_TOKEN, 1'b0, 32'hFFFFFFFE));
		send_item(mk(mrope_pkg::REQ_PAD, 1'b1, 32'hFFFFFFFF));
		send_item(mk(mrope_pkg::REQ_TOKEN, 1'b0, 32'd105));
		drain();

		random_phase(170);
		drain();
		write_merge(8'd1);
		hold_cycles = 3000;
		random_phase(170);
		drain();
		write_merge(8'd255);
		random_phase(120);
		drain();
		write_merge(8'd0);
		random_phase(150);
		drain();
		write_merge(8'd3);
		random_phase(120);
		drain();
		write_merge(8'd2);
		random_phase(100);

		@(negedge clk);
		in_valid <= 1'b0;
		drain();
		if (sb.pending_positions.size() != 0)
			sb.errors++;
		if (sb.errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
